### rtl/sbpr_pkg.sv
package sbpr_pkg;

	localparam int ADDR_W              = 64;
	localparam int RAS_MAX_DEF         = 16;
	localparam int HISTORY_ENTRIES_DEF = 16;
	localparam int CFG_DATA_W          = 5;
	localparam int CFG_INDEX_W         = 1;

	// request opcodes
	localparam logic OP_PREDICT = 1'b0;
	localparam logic OP_FLUSH   = 1'b1;

	// branch kinds
	localparam logic [2:0] KIND_COND   = 3'd0;
	localparam logic [2:0] KIND_UNCOND = 3'd1;
	localparam logic [2:0] KIND_CALL   = 3'd2;
	localparam logic [2:0] KIND_RET    = 3'd3;

	// static direction modes
	localparam logic [1:0] MODE_ALWAYS   = 2'd0;
	localparam logic [1:0] MODE_NEVER    = 2'd1;
	localparam logic [1:0] MODE_BACKWARD = 2'd2;
	localparam logic [1:0] MODE_FORWARD  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] CFG_STATIC_MODE = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_RAS_DEPTH   = 1'd1;

	localparam logic [CFG_DATA_W-1:0] RAS_DEPTH_RST = 5'd16;

	// stack cell operations
	typedef logic [1:0] stk_op_t;
	localparam stk_op_t STK_HOLD = 2'd0;
	localparam stk_op_t STK_PUSH = 2'd1;
	localparam stk_op_t STK_POP  = 2'd2;

	// history command broadcast to every cell
	typedef struct packed {
		logic              log;
		logic              flush;
		logic [ADDR_W-1:0] target;
	} hist_cmd_t;

	// search state handed from cell to cell
	typedef struct packed {
		logic hit;
		logic free;
	} hist_chain_t;

endpackage

### rtl/sbpr_req_if.sv
interface sbpr_req_if;
	logic                        valid;
	logic                        ready;
	logic                        opcode;
	logic [sbpr_pkg::ADDR_W-1:0] branch_address;
	logic [2:0]                  branch_kind;
	logic signed [63:0]          known_offset;
	logic [3:0]                  instr_length;

	modport source (output valid, output opcode, output branch_address, output branch_kind,
		output known_offset, output instr_length, input ready);
	modport sink (input valid, input opcode, input branch_address, input branch_kind,
		input known_offset, input instr_length, output ready);
endinterface

### rtl/sbpr_rsp_if.sv
interface sbpr_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        predicted_taken;
	logic [sbpr_pkg::ADDR_W-1:0] predicted_target;

	modport source (output valid, output predicted_taken, output predicted_target, input ready);
	modport sink (input valid, input predicted_taken, input predicted_target, output ready);
endinterface

### rtl/sbpr_stack_cell.sv
module sbpr_stack_cell (
	input  logic                        clk,
	input  sbpr_pkg::stk_op_t           op,
	input  logic [sbpr_pkg::ADDR_W-1:0] above,
	input  logic [sbpr_pkg::ADDR_W-1:0] below,
	output logic [sbpr_pkg::ADDR_W-1:0] value
);

	logic [sbpr_pkg::ADDR_W-1:0] val_q;

	// shift down on push, up on pop
	always_ff @(posedge clk) begin
		case (op)
			sbpr_pkg::STK_PUSH: val_q <= above;
			sbpr_pkg::STK_POP:  val_q <= below;
			default:            val_q <= val_q;
		endcase
	end

	assign value = val_q;

endmodule

### rtl/sbpr_hist_cell.sv
module sbpr_hist_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [sbpr_pkg::ADDR_W-1:0] key,
	input  sbpr_pkg::hist_cmd_t         cmd,
	input  sbpr_pkg::hist_chain_t       chain_in,
	output sbpr_pkg::hist_chain_t       chain_out,
	input  sbpr_pkg::hist_chain_t       chain_all,
	input  logic                        victim_here,
	output logic [sbpr_pkg::ADDR_W-1:0] hit_target
);

	logic [sbpr_pkg::ADDR_W-1:0] addr_q;
	logic [sbpr_pkg::ADDR_W-1:0] tgt_q;
	logic                        valid_q;
	logic                        match;
	logic                        first_hit;
	logic                        first_free;
	logic                        wr;
	logic                        clr;

	// compare and pass the search state on
	assign match           = valid_q && (addr_q == key);
	assign first_hit       = match && !chain_in.hit;
	assign first_free      = !valid_q && !chain_in.free;
	assign chain_out.hit   = chain_in.hit | match;
	assign chain_out.free  = chain_in.free | !valid_q;

	// claim this entry: matching one, else first free one, else the victim
	assign wr  = cmd.log && (first_hit
		|| (!chain_all.hit && first_free)
		|| (!chain_all.hit && !chain_all.free && victim_here));
	assign clr = cmd.flush && first_hit;

	assign hit_target = first_hit ? tgt_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (wr) begin
			valid_q <= 1'b1;
		end else if (clr) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			addr_q <= key;
			tgt_q  <= cmd.target;
		end
	end

endmodule

### rtl/static_branch_predictor_with_ras.sv
// A result is registered at the end of the cycle in which its request is accepted.
// One request per cycle while the result side is not stalled; the history search (one compare per cell, priority
// handed down the cell row) and the stack shift both finish in the accept cycle.
// A new request is taken while the held result is being taken.
// Reset clears the stack count, history valid bits, victim pointer and the output
// valid; static_mode returns to 0 and ras_depth to 16. Stack contents are not cleared.
module static_branch_predictor_with_ras #(
	parameter int RAS_MAX         = sbpr_pkg::RAS_MAX_DEF,
	parameter int HISTORY_ENTRIES = sbpr_pkg::HISTORY_ENTRIES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sbpr_req_if.sink                         req,
	sbpr_rsp_if.source                       rsp,
	input  logic                             cfg_wr_en,
	input  logic [sbpr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [sbpr_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int AW = sbpr_pkg::ADDR_W;
	localparam int CW = $clog2(RAS_MAX + 1);
	localparam int DW = (CW > sbpr_pkg::CFG_DATA_W) ? CW : sbpr_pkg::CFG_DATA_W;
	localparam int VW = (HISTORY_ENTRIES > 1) ? $clog2(HISTORY_ENTRIES) : 1;

	logic [1:0]                    static_mode_q;
	logic [sbpr_pkg::CFG_DATA_W-1:0] ras_depth_q;
	logic [CW-1:0]                 cnt_q;
	logic [VW-1:0]                 victim_q;
	logic                          rsp_valid_q;
	logic                          rsp_taken_q;
	logic [AW-1:0]                 rsp_target_q;

	logic                          acc;
	logic [AW-1:0]                 off_target;
	logic [AW-1:0]                 fall_through;
	logic                          neg;
	logic                          taken;
	logic [AW-1:0]                 target;
	sbpr_pkg::stk_op_t             stk_op;
	logic [AW-1:0]                 push_val;
	sbpr_pkg::hist_cmd_t           cmd;
	logic [DW-1:0]                 depth_use;
	logic [DW-1:0]                 depth_ext;

	logic [AW-1:0]                 stk_val [RAS_MAX];
	logic [AW-1:0]                 stk_above [RAS_MAX];
	logic [AW-1:0]                 stk_below [RAS_MAX];
	sbpr_pkg::hist_chain_t         chain [HISTORY_ENTRIES+1];
	logic [AW-1:0]                 hit_tgt [HISTORY_ENTRIES];
	logic [AW-1:0]                 flush_tgt;

	// request handshake
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;

	// address arithmetic
	assign off_target   = (req.known_offset != '0) ? (req.branch_address + AW'(req.known_offset))
		: '0;
	assign fall_through = req.branch_address + AW'(req.instr_length);
	assign neg          = req.known_offset[63];

	// clamp the configured depth
	assign depth_ext = DW'(ras_depth_q);
	assign depth_use = (ras_depth_q == '0) ? DW'(1)
		: ((depth_ext > DW'(RAS_MAX)) ? DW'(RAS_MAX) : depth_ext);

	// collect the logged target of the matching entry
	always_comb begin
		flush_tgt = '0;
		for (int i = 0; i < HISTORY_ENTRIES; i++) begin
			flush_tgt = flush_tgt | hit_tgt[i];
		end
	end

	// decode the request
	always_comb begin
		taken      = 1'b0;
		target     = '0;
		stk_op     = sbpr_pkg::STK_HOLD;
		push_val   = fall_through;
		cmd.log    = 1'b0;
		cmd.flush  = 1'b0;
		cmd.target = '0;
		if (req.opcode == sbpr_pkg::OP_FLUSH) begin
			cmd.flush = acc;
			if (chain[HISTORY_ENTRIES].hit) begin
				if (flush_tgt != '0) begin
					stk_op   = sbpr_pkg::STK_PUSH;
					push_val = flush_tgt;
				end else if (cnt_q != '0) begin
					stk_op = sbpr_pkg::STK_POP;
				end
			end
		end else begin
			case (req.branch_kind)
				sbpr_pkg::KIND_UNCOND: begin
					taken  = 1'b1;
					target = off_target;
				end
				sbpr_pkg::KIND_RET: begin
					taken  = 1'b1;
					target = off_target;
					if (cnt_q != '0) begin
						target     = stk_val[0];
						stk_op     = sbpr_pkg::STK_POP;
						cmd.log    = acc;
						cmd.target = stk_val[0];
					end
				end
				sbpr_pkg::KIND_CALL: begin
					taken   = 1'b1;
					target  = off_target;
					stk_op  = sbpr_pkg::STK_PUSH;
					cmd.log = acc;
				end
				sbpr_pkg::KIND_COND: begin
					case (static_mode_q)
						sbpr_pkg::MODE_ALWAYS: begin
							taken  = 1'b1;
							target = off_target;
						end
						sbpr_pkg::MODE_NEVER: begin
							taken  = 1'b0;
							target = '0;
						end
						sbpr_pkg::MODE_BACKWARD: begin
							taken  = neg;
							target = neg ? off_target : fall_through;
						end
						default: begin
							taken  = !neg && (req.known_offset != '0);
							target = taken ? off_target : fall_through;
						end
					endcase
				end
				default: begin
					taken  = 1'b0;
					target = '0;
				end
			endcase
		end
		if (!acc) begin
			stk_op = sbpr_pkg::STK_HOLD;
		end
	end

	// return stack: a row of cells, top at cell 0
	for (genvar i = 0; i < RAS_MAX; i++) begin : g_stk
		if (i == 0) begin : g_first
			assign stk_above[i] = push_val;
		end else begin : g_next
			assign stk_above[i] = stk_val[i-1];
		end
		if (i == RAS_MAX - 1) begin : g_last
			assign stk_below[i] = stk_val[i];
		end else begin : g_mid
			assign stk_below[i] = stk_val[i+1];
		end
		sbpr_stack_cell u_cell (
			.clk   (clk),
			.op    (stk_op),
			.above (stk_above[i]),
			.below (stk_below[i]),
			.value (stk_val[i])
		);
	end

	// history: a row of cells searched in index order
	assign chain[0] = '0;
	for (genvar i = 0; i < HISTORY_ENTRIES; i++) begin : g_hist
		sbpr_hist_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.key         (req.branch_address),
			.cmd         (cmd),
			.chain_in    (chain[i]),
			.chain_out   (chain[i+1]),
			.chain_all   (chain[HISTORY_ENTRIES]),
			.victim_here (victim_q == VW'(i)),
			.hit_target  (hit_tgt[i])
		);
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			static_mode_q <= sbpr_pkg::MODE_ALWAYS;
			ras_depth_q   <= sbpr_pkg::RAS_DEPTH_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				sbpr_pkg::CFG_STATIC_MODE: static_mode_q <= cfg_data[1:0];
				sbpr_pkg::CFG_RAS_DEPTH:   ras_depth_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// stack count and victim pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			victim_q <= '0;
		end else begin
			if (stk_op == sbpr_pkg::STK_PUSH) begin
				if (DW'(cnt_q) < depth_use) begin
					cnt_q <= cnt_q + CW'(1);
				end
			end else if (stk_op == sbpr_pkg::STK_POP) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.log && !chain[HISTORY_ENTRIES].hit && !chain[HISTORY_ENTRIES].free) begin
				victim_q <= (victim_q == VW'(HISTORY_ENTRIES - 1)) ? '0 : victim_q + VW'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (acc) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rsp_taken_q  <= taken;
			rsp_target_q <= target;
		end
	end

	assign rsp.valid            = rsp_valid_q;
	assign rsp.predicted_taken  = rsp_taken_q;
	assign rsp.predicted_target = rsp_target_q;

endmodule

### rtl/sbpr_checker.sv
module sbpr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_ready,
	input logic                        in_opcode,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic                        out_taken,
	input logic [sbpr_pkg::ADDR_W-1:0] out_target
);

	// no result in the cycle after reset is seen
	a_reset_quiet: assert property (@(posedge clk) !arst_n |=> !out_valid)
		else $error("result valid during reset");

	// every accepted request shows a result in the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> out_valid)
		else $error("result missing after accepted request");

	// a flush gives a not-taken zero result
	a_flush_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_opcode == sbpr_pkg::OP_FLUSH)
		|=> (!out_taken && out_target == '0))
		else $error("flush result not zero");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_taken) && $stable(out_target)))
		else $error("stalled result changed");

endmodule

bind static_branch_predictor_with_ras sbpr_checker u_sbpr_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (req.valid),
	.in_ready   (req.ready),
	.in_opcode  (req.opcode),
	.out_valid  (rsp.valid),
	.out_ready  (rsp.ready),
	.out_taken  (rsp.predicted_taken),
	.out_target (rsp.predicted_target)
);

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import sbpr_pkg::*;

	localparam int RAS_MAX     = RAS_MAX_DEF;
	localparam int HIST_N      = HISTORY_ENTRIES_DEF;
	localparam int PARK_CYCLES = 300;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 130;
	localparam int POOL_MAX    = 24;

	typedef struct {
		logic               opcode;
		logic [63:0]        address;
		logic [2:0]         kind;
		logic signed [63:0] offset;
		logic [3:0]         length;
	} branch_req_t;

	typedef struct {
		logic        taken;
		logic [63:0] target;
	} prediction_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wr_en;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	sbpr_req_if req_bus ();
	sbpr_rsp_if rsp_bus ();

	static_branch_predictor_with_ras dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the predictor state and its registers
	logic [1:0]  mode_setting;
	logic [4:0]  depth_setting;
	logic [63:0] ras_entry [RAS_MAX];
	int          ras_top;
	int          ras_count;
	logic [63:0] hist_addr [HIST_N];
	logic [63:0] hist_tgt [HIST_N];
	logic        hist_valid [HIST_N];
	int          hist_victim;

	branch_req_t pending_requests [$];
	prediction_t expected_predictions [$];
	branch_req_t in_flight;
	logic [63:0] site_pool [$];
	int          queued_count = 0;
	int          accepted_count = 0;
	int          mismatch_count = 0;
	logic        calm = 1'b0;
	logic        park_sink = 1'b0;
	int          park_count;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// return stack: push drops the oldest entry once the depth in use is reached
	function automatic void push_return(logic [63:0] value);
		int limit;
		limit = (depth_setting == 0) ? 1 : ((depth_setting > RAS_MAX) ? RAS_MAX : depth_setting);
		ras_top = (ras_top + 1) % RAS_MAX;
		ras_entry[ras_top] = value;
		if (ras_count < limit)
			ras_count++;
	endfunction

	function automatic logic [63:0] pop_return();
		logic [63:0] value;
		value = ras_entry[ras_top];
		ras_top = (ras_top + RAS_MAX - 1) % RAS_MAX;
		ras_count--;
		return value;
	endfunction

	function automatic int find_history(logic [63:0] address);
		int slot;
		slot = -1;
		for (int i = 0; i < HIST_N && slot < 0; i++)
			if (hist_valid[i] && hist_addr[i] == address)
				slot = i;
		return slot;
	endfunction

	// reuse a matching entry, else the lowest free one, else the round-robin victim
	function automatic void log_history(logic [63:0] address, logic [63:0] target);
		int slot;
		slot = find_history(address);
		for (int i = 0; i < HIST_N && slot < 0; i++)
			if (!hist_valid[i])
				slot = i;
		if (slot < 0) begin
			slot = hist_victim;
			hist_victim = (hist_victim + 1) % HIST_N;
		end
		hist_addr[slot] = address;
		hist_tgt[slot] = target;
		hist_valid[slot] = 1'b1;
	endfunction

	function automatic prediction_t predict_branch(branch_req_t r);
		prediction_t p;
		logic [63:0] off_target;
		logic [63:0] fall_through;
		int slot;
		off_target = (r.offset != 0) ? r.address + r.offset : 64'd0;
		fall_through = r.address + 64'(r.length);
		p.taken = 1'b0;
		p.target = 64'd0;
		if (r.opcode == OP_FLUSH) begin
			// undo the logged stack change, then free the entry
			slot = find_history(r.address);
			if (slot >= 0) begin
				if (hist_tgt[slot] != 0)
					push_return(hist_tgt[slot]);
				else if (ras_count > 0)
					void'(pop_return());
				hist_valid[slot] = 1'b0;
			end
		end else begin
			case (r.kind)
				KIND_UNCOND: begin
					p.taken = 1'b1;
					p.target = off_target;
				end
				KIND_CALL: begin
					push_return(fall_through);
					log_history(r.address, 64'd0);
					p.taken = 1'b1;
					p.target = off_target;
				end
				KIND_RET: begin
					p.taken = 1'b1;
					p.target = off_target;
					if (ras_count > 0) begin
						p.target = pop_return();
						log_history(r.address, p.target);
					end
				end
				KIND_COND: begin
					case (mode_setting)
						MODE_ALWAYS: begin
							p.taken = 1'b1;
							p.target = off_target;
						end
						MODE_NEVER: begin
							p.taken = 1'b0;
							p.target = 64'd0;
						end
						MODE_BACKWARD: begin
							p.taken = r.offset[63];
							p.target = r.offset[63] ? off_target : fall_through;
						end
						default: begin
							p.taken = !r.offset[63] && r.offset != 0;
							p.target = p.taken ? off_target : fall_through;
						end
					endcase
				end
				default: ;
			endcase
		end
		return p;
	endfunction

	// driver: hold the request until taken, then offer the next one or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid <= 1'b0;
			req_bus.opcode <= OP_PREDICT;
			req_bus.branch_address <= '0;
			req_bus.branch_kind <= KIND_COND;
			req_bus.known_offset <= '0;
			req_bus.instr_length <= '0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				expected_predictions.insert(expected_predictions.size(),
					predict_branch(in_flight));
				accepted_count++;
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (pending_requests.size() > 0 && (calm || $urandom_range(0, 99) >= 38)) begin
					in_flight = pending_requests[0];
					pending_requests.delete(0);
					req_bus.valid <= 1'b1;
					req_bus.opcode <= in_flight.opcode;
					req_bus.branch_address <= in_flight.address;
					req_bus.branch_kind <= in_flight.kind;
					req_bus.known_offset <= in_flight.offset;
					req_bus.instr_length <= in_flight.length;
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			park_count <= 0;
		end else begin
			if (rsp_bus.valid && rsp_bus.ready) begin
				if (expected_predictions.size() == 0) begin
					$display("%0t: result with no request pending: taken %0d target %h",
						$time, rsp_bus.predicted_taken, rsp_bus.predicted_target);
					mismatch_count++;
				end else begin
					prediction_t want;
					want = expected_predictions[0];
					expected_predictions.delete(0);
					if (rsp_bus.predicted_taken !== want.taken) begin
						$display("%0t: predicted_taken expected %0d actual %0d",
							$time, want.taken, rsp_bus.predicted_taken);
						mismatch_count++;
					end
					if (rsp_bus.predicted_target !== want.target) begin
						$display("%0t: predicted_target expected %h actual %h",
							$time, want.target, rsp_bus.predicted_target);
						mismatch_count++;
					end
				end
			end
			// hold off for a long stretch while parked, else stall at random unless calm
			if (park_sink && park_count < PARK_CYCLES) begin
				park_count <= park_count + 1;
				rsp_bus.ready <= 1'b0;
			end else begin
				if (!park_sink)
					park_count <= 0;
				rsp_bus.ready <= calm || $urandom_range(0, 99) >= 38;
			end
		end
	end

	function automatic branch_req_t make_req(logic opcode, logic [63:0] address, logic [2:0] kind,
		logic signed [63:0] offset, logic [3:0] length);
		branch_req_t r;
		r.opcode = opcode;
		r.address = address;
		r.kind = kind;
		r.offset = offset;
		r.length = length;
		return r;
	endfunction

	task automatic add_request(branch_req_t r);
		pending_requests.insert(pending_requests.size(), r);
		queued_count++;
		if (r.opcode == OP_PREDICT && (r.kind == KIND_CALL || r.kind == KIND_RET)) begin
			site_pool.insert(site_pool.size(), r.address);
			if (site_pool.size() > POOL_MAX)
				site_pool.delete(0);
		end
	endtask

	function automatic logic [63:0] pick_address();
		if (site_pool.size() > 0 && $urandom_range(0, 9) < 6)
			return site_pool[$urandom_range(0, site_pool.size() - 1)];
		return {$urandom, $urandom};
	endfunction

	function automatic logic signed [63:0] rand_offset();
		case ($urandom_range(0, 9))
			0, 1: return 64'sd0;
			2, 3: return -64'sd1 * $urandom_range(1, 4096);
			4, 5: return 64'sd1 * $urandom_range(1, 4096);
			6: return {1'b1, 63'd0};
			7: return {1'b0, {63{1'b1}}};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [3:0] rand_length();
		if ($urandom_range(0, 9) == 0)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(2, 15));
	endfunction

	function automatic logic [2:0] filler_kind();
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4, 5: return KIND_COND;
			6, 7: return KIND_UNCOND;
			default: return 3'($urandom_range(4, 7));
		endcase
	endfunction

	// one burst: mostly nested calls and returns with mispredict flushes, some noise
	task automatic queue_burst();
		int shape;
		int nest;
		logic [63:0] sites [$];
		logic [63:0] address;
		shape = $urandom_range(0, 9);
		if (shape <= 5) begin
			nest = $urandom_range(1, 6);
			for (int i = 0; i < nest; i++) begin
				address = pick_address();
				add_request(make_req(OP_PREDICT, address, KIND_CALL, rand_offset(), rand_length()));
				sites.insert(sites.size(), address);
				if ($urandom_range(0, 2) == 0)
					add_request(make_req(OP_PREDICT, {$urandom, $urandom}, filler_kind(),
						rand_offset(), rand_length()));
			end
			for (int i = 0; i < nest + $urandom_range(0, 1); i++) begin
				address = pick_address();
				add_request(make_req(OP_PREDICT, address, KIND_RET, rand_offset(), rand_length()));
				sites.insert(sites.size(), address);
			end
			if ($urandom_range(0, 1) == 0)
				while (sites.size() > 0) begin
					address = sites[sites.size() - 1];
					sites.delete(sites.size() - 1);
					if ($urandom_range(0, 3) != 0)
						add_request(make_req(OP_FLUSH, address, 3'($urandom_range(0, 7)),
							rand_offset(), rand_length()));
				end
		end else if (shape <= 7) begin
			add_request(make_req(1'($urandom_range(0, 1)), pick_address(),
				3'($urandom_range(0, 7)), rand_offset(), rand_length()));
		end else begin
			for (int i = 0; i < $urandom_range(1, 4); i++)
				add_request(make_req(OP_FLUSH, ($urandom_range(0, 9) < 8) ? pick_address() :
					{$urandom, $urandom}, 3'($urandom_range(0, 7)), rand_offset(), rand_length()));
		end
	endtask

	task automatic write_register(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		if (index == CFG_STATIC_MODE)
			mode_setting = value[1:0];
		else
			depth_setting = value;
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (accepted_count != queued_count || expected_predictions.size() != 0);
	endtask

	initial begin
		logic [1:0] mode;
		logic [4:0] depth;
		int phase_goal;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.opcode = OP_PREDICT;
		req_bus.branch_address = '0;
		req_bus.branch_kind = KIND_COND;
		req_bus.known_offset = '0;
		req_bus.instr_length = '0;
		rsp_bus.ready = 1'b0;
		mode_setting = MODE_ALWAYS;
		depth_setting = RAS_DEPTH_RST;
		ras_top = 0;
		ras_count = 0;
		hist_victim = 0;
		for (int i = 0; i < HIST_N; i++)
			hist_valid[i] = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed part under the reset settings
		add_request(make_req(OP_PREDICT, 64'h1000, KIND_UNCOND, 64'sd0, 4'd4));
		add_request(make_req(OP_PREDICT, '1, KIND_UNCOND, {1'b0, {63{1'b1}}}, 4'd15));
		add_request(make_req(OP_PREDICT, 64'd0, KIND_UNCOND, {1'b1, 63'd0}, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h2000, KIND_RET, -64'sd16, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h1000, KIND_CALL, 64'sh100, 4'd4));
		add_request(make_req(OP_PREDICT, 64'h1100, KIND_CALL, 64'sd0, 4'd15));
		add_request(make_req(OP_PREDICT, 64'h1180, KIND_COND, -64'sd8, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h1190, KIND_COND, 64'sd0, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h1200, KIND_RET, 64'sd0, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h1300, KIND_RET, 64'sd0, 4'd2));
		add_request(make_req(OP_FLUSH, 64'h1300, KIND_RET, 64'sd0, 4'd2));
		add_request(make_req(OP_FLUSH, 64'h1100, KIND_CALL, 64'sd0, 4'd15));
		add_request(make_req(OP_FLUSH, 64'h1100, KIND_CALL, 64'sd0, 4'd15));
		add_request(make_req(OP_PREDICT, 64'h1400, 3'd4, 64'sd64, 4'd4));
		add_request(make_req(OP_PREDICT, 64'h1410, 3'd7, -64'sd1, 4'd4));
		// return address wraps to zero, so the return is logged like a call
		add_request(make_req(OP_PREDICT, 64'hFFFF_FFFF_FFFF_FFFC, KIND_CALL, 64'sd8, 4'd4));
		add_request(make_req(OP_PREDICT, 64'h4000, KIND_RET, 64'sd0, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h5000, KIND_CALL, 64'sd32, 4'd2));
		add_request(make_req(OP_FLUSH, 64'h4000, KIND_RET, 64'sd0, 4'd2));
		add_request(make_req(OP_PREDICT, 64'h6000, KIND_CALL, 64'sd0, 4'd0));
		add_request(make_req(OP_PREDICT, 64'h6010, KIND_CALL, 64'sd0, 4'd1));
		add_request(make_req(OP_FLUSH, 64'h1000, KIND_RET, -64'sd3, 4'd9));
		add_request(make_req(OP_FLUSH, 64'h7777, KIND_COND, 64'sd0, 4'd2));
		add_request(make_req(OP_PREDICT, '1, KIND_UNCOND, 64'sd1, 4'd2));
		wait_drained();

		// random phases, each under its own register settings
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin mode = MODE_ALWAYS;   depth = 5'd16; end
				1: begin mode = MODE_NEVER;    depth = 5'd1;  end
				2: begin mode = MODE_BACKWARD; depth = 5'd4;  end
				3: begin mode = MODE_FORWARD;  depth = 5'd16; end
				4: begin mode = MODE_BACKWARD; depth = 5'd1;  end
				5: begin mode = MODE_FORWARD;  depth = 5'd2;  end
				6: begin mode = MODE_NEVER;    depth = 5'd8;  end
				default: begin mode = MODE_ALWAYS; depth = 5'd16; end
			endcase
			write_register(CFG_STATIC_MODE, CFG_DATA_W'(mode));
			write_register(CFG_RAS_DEPTH, depth);
			@(negedge clk);
			calm = (ph == 2);
			park_sink = (ph == 4);
			phase_goal = queued_count + PHASE_ITEMS;
			add_request(make_req(OP_PREDICT, {$urandom, $urandom}, KIND_COND, -64'sd4, 4'd2));
			add_request(make_req(OP_PREDICT, {$urandom, $urandom}, KIND_COND, 64'sd4, 4'd6));
			add_request(make_req(OP_PREDICT, {$urandom, $urandom}, KIND_COND, 64'sd0, 4'd3));
			while (queued_count < phase_goal)
				queue_burst();
			wait_drained();
			calm = 1'b0;
			park_sink = 1'b0;
		end

		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

### sim.f
rtl/sbpr_pkg.sv
rtl/sbpr_req_if.sv
rtl/sbpr_rsp_if.sv
rtl/sbpr_stack_cell.sv
rtl/sbpr_hist_cell.sv
rtl/static_branch_predictor_with_ras.sv
rtl/sbpr_checker.sv
tb/testbench.sv
